@@ hdl/md5sh_pkg.sv @@
// MD5 stream hasher package: state encoding, round constants, shift amounts.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none
package md5sh_pkg;

  localparam int unsigned ByteTotalWidth = 61;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUNDS,
    ST_ADD,
    ST_PAD,
    ST_LEN,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       put_byte;    // write the input byte at the current position
    logic       put_pad;     // write 0x80 and clear the rest of the block
    logic       clear_block; // clear the whole block
    logic       put_length;  // write the bit length into words 14 and 15
    logic       start_round; // load working words from the chaining words
    logic       do_round;    // run one round
    logic       finish;      // add working words into the chaining words
    logic       reset_msg;   // restore initial chaining words and count
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic block_full;  // the byte just written filled the block
    logic pad_spills;  // padding byte lands at position 56 or later
    logic rounds_done; // round 63 is running
  } dp_status_t;

  localparam logic [31:0] InitA = 32'h67452301;
  localparam logic [31:0] InitB = 32'hefcdab89;
  localparam logic [31:0] InitC = 32'h98badcfe;
  localparam logic [31:0] InitD = 32'h10325476;
  localparam logic [7:0]  PadByte = 8'h80;

  function automatic logic [31:0] round_const(input logic [5:0] i);
    logic [31:0] k;
    unique case (i)
      6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;  6'd2: k = 32'h242070db;
      6'd3: k = 32'hc1bdceee;  6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;  6'd8: k = 32'h698098d8;
      6'd9: k = 32'h8b44f7af;  6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
      default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] rot_amount(input logic [5:0] i);
    logic [4:0] s;
    unique case ({i[5:4], i[1:0]})
      4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
      4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
      4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
      4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

@@ hdl/md5sh_datapath.sv @@
// MD5 datapath: block store, byte count, chaining words and the round unit.
// Depends on md5sh_pkg for commands, status and round tables.
`timescale 1ns / 1ps
`default_nettype none
module md5sh_datapath (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire md5sh_pkg::dp_cmd_t    cmd,
  input  wire logic [7:0]            data_byte,
  input  wire logic [1:0]            emit_index,
  output md5sh_pkg::dp_status_t      status,
  output logic [31:0]                emit_word
);

  logic [31:0] block [16];
  logic [31:0] chain [4];
  logic [31:0] wa, wb, wc, wd;
  logic [md5sh_pkg::ByteTotalWidth-1:0] byte_total;
  logic [5:0]  round;

  logic [5:0]  pos;
  logic [63:0] bit_len;
  logic [31:0] f;
  logic [3:0]  m;
  logic [31:0] sum;
  logic [31:0] rot;
  logic [4:0]  s;

  assign pos     = byte_total[5:0];
  assign bit_len = {byte_total, 3'b000};

  // Round function and message word select.
  always_comb begin
    unique case (round[5:4])
      2'd0: begin f = wd ^ (wb & (wc ^ wd)); m = round[3:0]; end
      2'd1: begin f = wc ^ (wd & (wb ^ wc)); m = 4'(5 * round + 1); end
      2'd2: begin f = wb ^ wc ^ wd;          m = 4'(3 * round + 5); end
      default: begin f = wc ^ (wb | ~wd);    m = 4'(7 * round); end
    endcase
    s   = md5sh_pkg::rot_amount(round);
    sum = wa + f + md5sh_pkg::round_const(round) + block[m];
    rot = (sum << s) | (sum >> (6'd32 - {1'b0, s}));
  end

  assign status.block_full  = cmd.put_byte && (pos == 6'd63);
  assign status.pad_spills  = (pos >= 6'd56);
  assign status.rounds_done = (round == 6'd63);
  assign emit_word = chain[emit_index];

  // Block store writes; the length words take priority over clearing and padding.
  always_ff @(posedge clk) begin
    for (int w = 0; w < 16; w++) begin
      if (cmd.put_length && (w >= 14)) begin
        block[w] <= (w == 14) ? bit_len[31:0] : bit_len[63:32];
      end else if (cmd.clear_block) begin
        block[w] <= '0;
      end else if (cmd.put_pad) begin
        for (int j = 0; j < 4; j++) begin
          if (6'(4 * w + j) == pos) begin
            block[w][8*j +: 8] <= md5sh_pkg::PadByte;
          end else if (6'(4 * w + j) > pos) begin
            block[w][8*j +: 8] <= 8'h00;
          end
        end
      end else if (cmd.put_byte && pos[5:2] == 4'(w)) begin
        block[w][8*pos[1:0] +: 8] <= data_byte;
      end
    end
  end

  // Working words and round counter.
  always_ff @(posedge clk) begin
    if (cmd.start_round) begin
      wa <= chain[0]; wb <= chain[1]; wc <= chain[2]; wd <= chain[3];
      round <= '0;
    end else if (cmd.do_round) begin
      wa <= wd; wd <= wc; wc <= wb;
      wb <= wb + rot;
      round <= round + 6'd1;
    end
  end

  // Chaining words and byte count.
  always_ff @(posedge clk) begin
    if (rst || cmd.reset_msg) begin
      chain[0] <= md5sh_pkg::InitA; chain[1] <= md5sh_pkg::InitB;
      chain[2] <= md5sh_pkg::InitC; chain[3] <= md5sh_pkg::InitD;
      byte_total <= '0;
    end else begin
      if (cmd.finish) begin
        chain[0] <= chain[0] + wa; chain[1] <= chain[1] + wb;
        chain[2] <= chain[2] + wc; chain[3] <= chain[3] + wd;
      end
      if (cmd.put_byte) begin
        byte_total <= byte_total + 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

@@ hdl/md5sh_controller.sv @@
// MD5 controller: accepts beats, sequences rounds, padding and digest output.
// Depends on md5sh_pkg for the state type, commands and status.
`timescale 1ns / 1ps
`default_nettype none
module md5sh_controller (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_fire,
  input  wire logic                   in_byte_valid,
  input  wire logic                   in_last,
  input  wire logic                   out_ready,
  input  wire md5sh_pkg::dp_status_t  status,
  output md5sh_pkg::dp_cmd_t          cmd,
  output logic                        in_ready,
  output logic                        out_valid,
  output logic [1:0]                  emit_index
);

  md5sh_pkg::state_t state, state_next;
  logic pend_last, pend_last_next;   // finish the message after these rounds
  logic pend_len, pend_len_next;     // a zero block with the length comes next
  logic final_blk, final_blk_next;   // the rounds running are the length block
  logic [1:0] emit_index_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= md5sh_pkg::ST_IDLE;
      pend_last <= 1'b0;
      pend_len <= 1'b0;
      final_blk <= 1'b0;
      emit_index <= '0;
    end else begin
      state <= state_next;
      pend_last <= pend_last_next;
      pend_len <= pend_len_next;
      final_blk <= final_blk_next;
      emit_index <= emit_index_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    pend_last_next = pend_last;
    pend_len_next = pend_len;
    final_blk_next = final_blk;
    emit_index_next = emit_index;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      md5sh_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          cmd.put_byte = in_byte_valid;
          if (status.block_full) begin
            cmd.start_round = 1'b1;
            pend_last_next = in_last;
            final_blk_next = 1'b0;
            state_next = md5sh_pkg::ST_ROUNDS;
          end else if (in_last) begin
            state_next = md5sh_pkg::ST_PAD;
          end
        end
      end
      md5sh_pkg::ST_ROUNDS: begin
        cmd.do_round = 1'b1;
        if (status.rounds_done) begin
          state_next = md5sh_pkg::ST_ADD;
        end
      end
      md5sh_pkg::ST_ADD: begin
        // Fold the working words into the chain, then pick what follows.
        cmd.finish = 1'b1;
        if (final_blk) begin
          state_next = md5sh_pkg::ST_EMIT;
          emit_index_next = '0;
        end else if (pend_len) begin
          state_next = md5sh_pkg::ST_LEN;
        end else if (pend_last) begin
          state_next = md5sh_pkg::ST_PAD;
        end else begin
          state_next = md5sh_pkg::ST_IDLE;
        end
      end
      md5sh_pkg::ST_PAD: begin
        // Padding goes at the current position.
        cmd.put_pad = 1'b1;
        cmd.start_round = 1'b1;
        pend_last_next = 1'b0;
        if (status.pad_spills) begin
          // Compress the padded block, then a zero block with the length.
          pend_len_next = 1'b1;
          final_blk_next = 1'b0;
        end else begin
          cmd.put_length = 1'b1;
          final_blk_next = 1'b1;
        end
        state_next = md5sh_pkg::ST_ROUNDS;
      end
      md5sh_pkg::ST_LEN: begin
        // Zero block that carries only the bit length.
        cmd.clear_block = 1'b1;
        cmd.put_length = 1'b1;
        cmd.start_round = 1'b1;
        pend_len_next = 1'b0;
        final_blk_next = 1'b1;
        state_next = md5sh_pkg::ST_ROUNDS;
      end
      md5sh_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          emit_index_next = emit_index + 2'd1;
          if (emit_index == 2'd3) begin
            cmd.reset_msg = 1'b1;
            final_blk_next = 1'b0;
            state_next = md5sh_pkg::ST_IDLE;
          end
        end
      end
      default: state_next = md5sh_pkg::ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

@@ hdl/md5sh_sequencer.sv @@
// Command stage between the controller and the datapath: forwards the
// controller's commands unchanged. Depends on md5sh_pkg.
`timescale 1ns / 1ps
`default_nettype none
module md5sh_sequencer (
  input  wire md5sh_pkg::dp_cmd_t  ctl_cmd,
  output md5sh_pkg::dp_cmd_t       dp_cmd
);
  // Commands reach the datapath in the cycle they are issued.
  assign dp_cmd = ctl_cmd;
endmodule
`default_nettype wire

@@ hdl/md5_stream_hasher_unit.sv @@
// MD5 stream hasher top level: controller plus datapath.
// A byte that fills a block closes the input while the rounds run and until the add is done.
// A last beat takes, per padded block (one, or two when the pad passes byte 55), a setup
// step, the rounds and an add step, then four output beats. Other bytes go one per cycle
// while s_tready is high. One shared round unit sets the rate.
// Reset (rst, synchronous) restores the initial chaining words and a zero count.
`timescale 1ns / 1ps
`default_nettype none
module md5_stream_hasher_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,  // [7:0] data_byte, [8] byte_valid, [15:9] zero
  input  wire logic        s_tlast,  // last
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,  // [31:0] digest_word, [33:32] word_index, [39:34] zero
  output logic             m_tlast   // last_word
);

  md5sh_pkg::dp_cmd_t    ctl_cmd, dp_cmd;
  md5sh_pkg::dp_status_t status;
  logic [1:0]  emit_index;
  logic [31:0] emit_word;
  logic        in_fire;

  assign in_fire = s_tvalid && s_tready;

  md5sh_controller u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .in_byte_valid(s_tdata[8]),
    .in_last(s_tlast), .out_ready(m_tready), .status(status), .cmd(ctl_cmd),
    .in_ready(s_tready), .out_valid(m_tvalid), .emit_index(emit_index)
  );

  md5sh_sequencer u_seq (
    .ctl_cmd(ctl_cmd), .dp_cmd(dp_cmd)
  );

  md5sh_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(dp_cmd), .data_byte(s_tdata[7:0]),
    .emit_index(emit_index), .status(status), .emit_word(emit_word)
  );

  assign m_tdata = {6'b0, emit_index, emit_word};
  assign m_tlast = (emit_index == 2'd3);

endmodule
`default_nettype wire

@@ hdl/md5sh_checker.sv @@
// Port checker for the MD5 stream hasher, bound to the top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
`default_nettype none
module md5sh_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [39:0] m_tdata,
  input wire logic        m_tlast
);
  // Input and output never overlap.
  a_excl: assert property (@(posedge clk) disable iff (rst) !(s_tready && m_tvalid))
    else $error("input ready while digest pending");
  // Output held while stalled.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("digest beat dropped");
  // Word index 3 carries tlast.
  a_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tdata[33:32] == 2'd3)))
    else $error("tlast mismatch");
  // After the final word the block returns to accepting input.
  a_ret: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast |=> s_tready)
    else $error("not idle after digest");
endmodule

bind md5_stream_hasher_unit md5sh_checker u_chk (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
);
`default_nettype wire

@@ tb/sv/md5_digest_checker.sv @@
// Checker for the MD5 stream hasher: watches both streams, predicts digests.
// Self-contained MD5 predictor; depends only on the port layout of the block.
`timescale 1ns / 1ps
module md5_digest_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [15:0] s_tdata,
  input  wire logic        s_tlast,
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [39:0] m_tdata,
  input  wire logic        m_tlast,
  output int               fail_count,
  output int               pending,
  output int               digests_seen
);

  typedef struct packed {
    logic [31:0] word;
    logic [1:0]  index;
    logic        final_word;
  } digest_beat_t;

  digest_beat_t digest_queue[$];
  logic [31:0] chain[4];
  logic [31:0] blk[16];
  logic [60:0] total;

  function automatic logic [31:0] sine_const(input int i);
    logic [31:0] k[64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee, 32'hf57c0faf, 32'h4787c62a,
      32'ha8304613, 32'hfd469501, 32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821, 32'hf61e2562, 32'hc040b340,
      32'h265e5a51, 32'he9b6c7aa, 32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed, 32'ha9e3e905, 32'hfcefa3f8,
      32'h676f02d9, 32'h8d2a4c8a, 32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70, 32'h289b7ec6, 32'heaa127fa,
      32'hd4ef3085, 32'h04881d05, 32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039, 32'h655b59c3, 32'h8f0ccc92,
      32'hffeff47d, 32'h85845dd1, 32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
    return k[i];
  endfunction

  task automatic init_chain();
    chain[0] = 32'h67452301;
    chain[1] = 32'hefcdab89;
    chain[2] = 32'h98badcfe;
    chain[3] = 32'h10325476;
    total = '0;
  endtask

  task automatic compress();
    logic [31:0] a, b, c, d, f, t, sum;
    int m, grp, s;
    int rot[16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
    for (int i = 0; i < 64; i++) begin
      grp = i / 16;
      case (grp)
        0: begin f = d ^ (b & (c ^ d)); m = i % 16; end
        1: begin f = c ^ (d & (b ^ c)); m = (5 * i + 1) % 16; end
        2: begin f = b ^ c ^ d; m = (3 * i + 5) % 16; end
        default: begin f = c ^ (b | ~d); m = (7 * i) % 16; end
      endcase
      s = rot[grp * 4 + i % 4];
      sum = a + f + sine_const(i) + blk[m];
      t = d; d = c; c = b;
      b = b + ((sum << s) | (sum >> (32 - s)));
      a = t;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
  endtask

  task automatic write_byte(input int pos, input logic [7:0] v);
    blk[pos / 4][(pos % 4) * 8 +: 8] = v;
  endtask

  // Apply one accepted input beat to the predicted state.
  task automatic hash_beat(input logic [7:0] data, input logic valid, input logic fin);
    int pos;
    logic [63:0] bits;
    digest_beat_t e;
    if (valid) begin
      pos = int'(total[5:0]);
      write_byte(pos, data);
      total = total + 61'd1;
      if (pos == 63) compress();
    end
    if (fin) begin
      pos = int'(total[5:0]);
      bits = {total, 3'b000};
      write_byte(pos, 8'h80);
      for (int k = pos + 1; k < 64; k++) write_byte(k, 8'h00);
      if (pos >= 56) begin
        compress();
        for (int k = 0; k < 16; k++) blk[k] = '0;
      end
      blk[14] = bits[31:0];
      blk[15] = bits[63:32];
      compress();
      for (int k = 0; k < 4; k++) begin
        e.word = chain[k];
        e.index = 2'(k);
        e.final_word = (k == 3);
        digest_queue.push_back(e);
      end
      init_chain();
    end
  endtask

  initial begin
    fail_count = 0;
    digests_seen = 0;
    for (int k = 0; k < 16; k++) blk[k] = '0;
    init_chain();
  end

  assign pending = digest_queue.size();

  // Sample both channels at each rising edge.
  always @(posedge clk) begin
    digest_beat_t exp_beat;
    if (rst) begin
      init_chain();
    end else begin
      if (s_tvalid && s_tready) hash_beat(s_tdata[7:0], s_tdata[8], s_tlast);
      if (m_tvalid && m_tready) begin
        if (digest_queue.size() == 0) begin
          $display("%0t: unexpected digest beat data=%h last=%b", $time, m_tdata, m_tlast);
          fail_count++;
        end else begin
          exp_beat = digest_queue.pop_front();
          if (m_tdata[31:0] !== exp_beat.word || m_tdata[33:32] !== exp_beat.index ||
              m_tdata[39:34] !== 6'd0 || m_tlast !== exp_beat.final_word) begin
            $display("%0t: mismatch expected word=%h idx=%0d last=%b, got data=%h last=%b",
                     $time, exp_beat.word, exp_beat.index, exp_beat.final_word,
                     m_tdata, m_tlast);
            fail_count++;
          end
          if (exp_beat.final_word) digests_seen++;
        end
      end
    end
  end

endmodule

@@ tb/sv/tb.sv @@
// Testbench top for the MD5 stream hasher: clock, reset, byte stimulus, verdict.
// Depends on md5_stream_hasher_unit and md5_digest_checker.
`timescale 1ns / 1ps
module tb;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        m_tlast;
  int          fail_count, pending, digests_seen;
  int          send_idle_pct = 0, recv_idle_pct = 0;
  bit          recv_hold = 1'b0;
  int          beats_sent = 0;

  always #4 clk = ~clk;

  md5_stream_hasher_unit dut (.*);

  md5_digest_checker chk (.*);

  // Receiver: random back-pressure plus an optional long hold-off.
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  // Drive one beat, with random idle cycles before it, and wait for acceptance.
  task automatic send_beat(input logic [7:0] data, input logic valid, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {7'd0, valid, data};
    s_tlast <= fin;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    beats_sent++;
  endtask

  // A message of n random bytes; the final byte may carry the last flag.
  task automatic send_message(input int n);
    bit joined;
    joined = $urandom_range(1) && n > 0;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(15) == 0) send_beat(8'($urandom), 1'b0, 1'b0);
      send_beat(8'($urandom), 1'b1, joined && i == n - 1);
    end
    if (!joined) send_beat(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty message, extremes, pad boundaries, idle beats.
    send_beat(8'h00, 1'b0, 1'b1);
    send_beat(8'hff, 1'b0, 1'b0);
    send_beat(8'hff, 1'b1, 1'b1);
    send_beat(8'h00, 1'b1, 1'b0);
    send_beat(8'hff, 1'b1, 1'b0);
    send_beat(8'h5a, 1'b0, 1'b1);
    drain();
    send_message(55);
    send_message(56);
    send_message(64);
    drain();

    // Long receiver hold-off while the sender keeps offering.
    recv_hold <= 1'b1;
    fork
      begin
        send_message(3);
        send_message(2);
        send_message(4);
      end
      begin
        repeat (600) @(posedge clk);
        recv_hold <= 1'b0;
      end
    join
    drain();

    // Random messages through three idle profiles.
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 34 : (phase == 1) ? 63 : 0;
      recv_idle_pct = (phase == 0) ? 63 : (phase == 1) ? 34 : 0;
      for (int m = 0; m < 4; m++) begin
        if ($urandom_range(9) == 0) send_message($urandom_range(130));
        else send_message($urandom_range(20));
      end
      drain();
    end

    repeat (300) @(posedge clk);
    $display("Covered %0d input beats and %0d digests across three idle profiles.",
             beats_sent, digests_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ files.f @@
hdl/md5sh_pkg.sv
hdl/md5sh_datapath.sv
hdl/md5sh_controller.sv
hdl/md5sh_sequencer.sv
hdl/md5_stream_hasher_unit.sv
hdl/md5sh_checker.sv
tb/sv/md5_digest_checker.sv
tb/sv/tb.sv
